@@ src/r2fft_pkg.sv @@
package r2fft_pkg;

  localparam int FRAME_LOG  = 6;
  localparam int FRAME_SIZE = 1 << FRAME_LOG;
  localparam int HALF       = FRAME_SIZE / 2;
  localparam int TW_BITS    = 16;
  localparam int DATA_W     = 24;
  localparam int SMP_W      = 16;
  localparam int BIN_W      = 6;
  localparam int VAL_W      = 43;
  localparam int PWR_W      = 48;
  localparam int PROD_W     = DATA_W + TW_BITS;
  localparam int STG_W      = $clog2(FRAME_LOG);

  localparam logic [VAL_W-1:0] VALUE_MAX = {VAL_W{1'b1}};

  // One sample on its way to the store
  typedef struct packed {
    logic [FRAME_LOG-1:0]    addr;
    logic signed [SMP_W-1:0] smp;
    logic                    last;
  } load_item_t;

  typedef logic signed [TW_BITS-1:0] tw_t;

  typedef struct packed {
    tw_t c;
    tw_t s;
  } tw_pair_t;

  typedef enum logic [9:0] {
    S_LOAD = 10'b0000000001,
    S_RD   = 10'b0000000010,
    S_MUL  = 10'b0000000100,
    S_WR0  = 10'b0000001000,
    S_WR1  = 10'b0000010000,
    S_ERD  = 10'b0000100000,
    S_ESQ  = 10'b0001000000,
    S_ESUM = 10'b0010000000,
    S_SQRT = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } back_state_e;

  // sin(k*pi/32) in Q1.15 for k = 0..16, capped at full scale
  function automatic tw_t quarter_sin(input logic [FRAME_LOG-2:0] k);
    tw_t v;
    case (k)
      5'd0:    v = 16'sd0;
      5'd1:    v = 16'sd3212;
      5'd2:    v = 16'sd6393;
      5'd3:    v = 16'sd9512;
      5'd4:    v = 16'sd12540;
      5'd5:    v = 16'sd15447;
      5'd6:    v = 16'sd18205;
      5'd7:    v = 16'sd20788;
      5'd8:    v = 16'sd23170;
      5'd9:    v = 16'sd25330;
      5'd10:   v = 16'sd27246;
      5'd11:   v = 16'sd28899;
      5'd12:   v = 16'sd30274;
      5'd13:   v = 16'sd31357;
      5'd14:   v = 16'sd32138;
      5'd15:   v = 16'sd32610;
      default: v = 16'sd32767;
    endcase
    return v;
  endfunction

  // cos and +sin of 2*pi*t/FRAME_SIZE
  function automatic tw_pair_t twiddle(input logic [FRAME_LOG-2:0] t);
    tw_pair_t p;
    if (t < (FRAME_LOG-1)'(FRAME_SIZE / 4)) begin
      p.c = quarter_sin((FRAME_LOG-1)'(FRAME_SIZE / 4) - t);
      p.s = quarter_sin(t);
    end else begin
      p.c = -quarter_sin(t - (FRAME_LOG-1)'(FRAME_SIZE / 4));
      p.s = quarter_sin((FRAME_LOG-1)'(0) - t);
    end
    return p;
  endfunction

endpackage

@@ src/r2fft_front.sv @@
module r2fft_front
  import r2fft_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [SMP_W-1:0] sample_i,
  output logic                    push_o,
  output load_item_t              item_o,
  input  logic                    full_i
);

  logic [FRAME_LOG-1:0] count_q, count_d;
  logic [FRAME_LOG-1:0] rev;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // bit-reverse the frame position
  always_comb begin
    for (int i = 0; i < FRAME_LOG; i++) begin
      rev[i] = count_q[FRAME_LOG-1-i];
    end
  end

  assign item_o.addr = rev;
  assign item_o.smp  = sample_i;
  assign item_o.last = (count_q == (FRAME_LOG)'(FRAME_SIZE - 1));

  // advance the frame position on each item
  assign count_d = push_o ? count_q + 1'b1 : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

@@ src/r2fft_fifo.sv @@
module r2fft_fifo
  import r2fft_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  load_item_t item_i,
  output logic       full_o,
  output logic       valid_o,
  output load_item_t item_o,
  input  logic       pop_i
);

  load_item_t    slot_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = slot_q[rd_q];

  // hold payload in the slot
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= item_i;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

@@ src/r2fft_back.sv @@
module r2fft_back
  import r2fft_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             mode_i,
  input  logic             valid_i,
  input  load_item_t       item_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [BIN_W-1:0] bin_index_o,
  output logic [VAL_W-1:0] bin_value_o,
  output logic             last_bin_o
);

  localparam logic signed [PROD_W:0] RND = (PROD_W+1)'(1) <<< (TW_BITS - 2);

  back_state_e state_q, state_d;

  logic signed [DATA_W-1:0] re_mem [FRAME_SIZE];
  logic signed [DATA_W-1:0] im_mem [FRAME_SIZE];

  logic signed [DATA_W-1:0] re0_q, im0_q, re1_q, im1_q;
  logic [FRAME_LOG-1:0]     ra0, ra1, wa;
  logic                     rd_en, we;
  logic signed [DATA_W-1:0] wre, wim;

  logic [STG_W-1:0]     stage_q;
  logic [FRAME_LOG-2:0] bfly_q;
  logic [FRAME_LOG:0]   bin_q;
  logic [FRAME_LOG-1:0] mask, bx, k, k1;
  logic [FRAME_LOG-2:0] ti;
  tw_pair_t             tw;

  logic signed [PROD_W-1:0] p_cr_q, p_si_q, p_ci_q, p_sr_q;
  logic signed [PROD_W:0]   tr_sum, ti_sum, tr_sh, ti_sh;
  logic signed [DATA_W-1:0] tr, tim;

  logic [DATA_W-1:0] ar, am;
  logic [PWR_W-1:0]  sq_re_q, sq_im_q, pwr, pv;
  logic [PWR_W-1:0]  rem_q, root_q, bit_q, trial;
  logic [PWR_W-1:0]  rem_d, root_d;
  logic [VAL_W-1:0]  val_q;
  logic              edge_bin;

  logic             out_valid_q;
  logic [BIN_W-1:0] out_idx_q;
  logic [VAL_W-1:0] out_val_q;
  logic             out_last_q;
  logic             out_load;

  // butterfly addresses for the current stage
  assign mask = ((FRAME_LOG)'(1) << stage_q) - 1'b1;
  assign bx   = {1'b0, bfly_q};
  assign k    = ({bfly_q, 1'b0} & ~{mask[FRAME_LOG-2:0], 1'b1}) | (bx & mask);
  assign k1   = k | ((FRAME_LOG)'(1) << stage_q);
  assign ti   = (FRAME_LOG-1)'((bx & mask) << ((STG_W)'(FRAME_LOG - 1) - stage_q));
  assign tw   = twiddle(ti);

  // round the rotated odd point, ties toward +infinity
  assign tr_sum = (PROD_W+1)'(p_cr_q) - (PROD_W+1)'(p_si_q) + RND;
  assign ti_sum = (PROD_W+1)'(p_ci_q) + (PROD_W+1)'(p_sr_q) + RND;
  assign tr_sh  = tr_sum >>> (TW_BITS - 1);
  assign ti_sh  = ti_sum >>> (TW_BITS - 1);
  assign tr     = DATA_W'(tr_sh);
  assign tim    = DATA_W'(ti_sh);

  // memory ports
  always_comb begin
    rd_en = 1'b0;
    ra0   = k;
    ra1   = k1;
    we    = 1'b0;
    wa    = item_i.addr;
    wre   = DATA_W'(item_i.smp);
    wim   = '0;
    pop_o = 1'b0;
    case (state_q)
      S_LOAD: begin
        pop_o = valid_i;
        we    = valid_i;
      end
      S_RD: rd_en = 1'b1;
      S_WR0: begin
        we  = 1'b1;
        wa  = k;
        wre = re0_q + tr;
        wim = im0_q + tim;
      end
      S_WR1: begin
        we  = 1'b1;
        wa  = k1;
        wre = re0_q - tr;
        wim = im0_q - tim;
      end
      S_ERD: begin
        rd_en = 1'b1;
        ra0   = bin_q[FRAME_LOG-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      re_mem[wa] <= wre;
      im_mem[wa] <= wim;
    end
    if (rd_en) begin
      re0_q <= re_mem[ra0];
      im0_q <= im_mem[ra0];
      re1_q <= re_mem[ra1];
      im1_q <= im_mem[ra1];
    end
  end

  // magnitude and power datapath
  assign ar       = re0_q[DATA_W-1] ? DATA_W'(-re0_q) : DATA_W'(re0_q);
  assign am       = im0_q[DATA_W-1] ? DATA_W'(-im0_q) : DATA_W'(im0_q);
  assign pwr      = sq_re_q + sq_im_q;
  assign edge_bin = (bin_q == '0) || (bin_q == (FRAME_LOG+1)'(HALF));
  assign pv       = edge_bin ? (pwr >> 2) : pwr;

  // one result bit per square root step
  assign trial = root_q + bit_q;
  always_comb begin
    if (rem_q >= trial) begin
      rem_d  = rem_q - trial;
      root_d = (root_q >> 1) + bit_q;
    end else begin
      rem_d  = rem_q;
      root_d = root_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_MUL: begin
        p_cr_q <= tw.c * re1_q;
        p_si_q <= tw.s * im1_q;
        p_ci_q <= tw.c * im1_q;
        p_sr_q <= tw.s * re1_q;
      end
      S_ESQ: begin
        sq_re_q <= PWR_W'(ar) * PWR_W'(ar);
        sq_im_q <= PWR_W'(am) * PWR_W'(am);
      end
      S_ESUM: begin
        rem_q  <= pwr;
        root_q <= '0;
        bit_q  <= (PWR_W)'(1) << (PWR_W - 2);
        val_q  <= (pv > PWR_W'(VALUE_MAX)) ? VALUE_MAX : VAL_W'(pv);
      end
      S_SQRT: begin
        rem_q  <= rem_d;
        root_q <= root_d;
        bit_q  <= bit_q >> 2;
        val_q  <= VAL_W'(root_d);
      end
      default: ;
    endcase
  end

  // sequence load, butterflies and bin emission
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD: if (valid_i && item_i.last) state_d = S_RD;
      S_RD:   state_d = S_MUL;
      S_MUL:  state_d = S_WR0;
      S_WR0:  state_d = S_WR1;
      S_WR1: begin
        if (bfly_q == (FRAME_LOG-1)'(HALF - 1) && stage_q == (STG_W)'(FRAME_LOG - 1)) begin
          state_d = S_ERD;
        end else begin
          state_d = S_RD;
        end
      end
      S_ERD:  state_d = S_ESQ;
      S_ESQ:  state_d = S_ESUM;
      S_ESUM: state_d = mode_i ? S_OUT : S_SQRT;
      S_SQRT: if (bit_q[0]) state_d = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_d = (bin_q == (FRAME_LOG+1)'(HALF)) ? S_LOAD : S_ERD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      stage_q <= '0;
      bfly_q  <= '0;
      bin_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_LOAD) begin
        stage_q <= '0;
        bfly_q  <= '0;
        bin_q   <= '0;
      end
      if (state_q == S_WR1) begin
        bfly_q <= bfly_q + 1'b1;
        if (bfly_q == (FRAME_LOG-1)'(HALF - 1)) begin
          stage_q <= stage_q + 1'b1;
        end
      end
      if (out_load) begin
        bin_q <= bin_q + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q  <= BIN_W'(bin_q);
      out_val_q  <= val_q;
      out_last_q <= (bin_q == (FRAME_LOG+1)'(HALF));
    end
  end

  assign out_valid_o = out_valid_q;
  assign bin_index_o = out_idx_q;
  assign bin_value_o = out_val_q;
  assign last_bin_o  = out_last_q;

endmodule

@@ src/radix2_fft_spectrum.sv @@
// Spectrum of one 64-sample frame: samples enter one per item through a
// two-entry queue at up to one per cycle and land at bit-reversed addresses.
// After the 64th sample one shared butterfly unit runs the 6-stage FFT, each
// butterfly reading both points, multiplying, then writing the sum and the
// difference, while input stalls once the queue fills. Bins 0..32 then leave
// in order; in magnitude mode each waits on a square root that yields one
// result bit per cycle. A new frame loads once the last bin is registered.
// output_mode is sampled while the bins are emitted.
module radix2_fft_spectrum
  import r2fft_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [SMP_W-1:0] sample_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [BIN_W-1:0]        bin_index_o,
  output logic [VAL_W-1:0]        bin_value_o,
  output logic                    last_bin_o
);

  logic       mode_q;
  logic       push, full, q_valid, pop;
  load_item_t push_item, q_item;

  // hold the output mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_data_i;
    end
  end

  r2fft_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .push_o     (push),
    .item_o     (push_item),
    .full_i     (full)
  );

  r2fft_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (pop)
  );

  r2fft_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .valid_i     (q_valid),
    .item_i      (q_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .bin_index_o (bin_index_o),
    .bin_value_o (bin_value_o),
    .last_bin_o  (last_bin_o)
  );

`ifndef ASSERT_OFF
  a_last_is_nyquist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_bin_o |-> bin_index_o == BIN_W'(HALF))
    else $error("last bin flag off the Nyquist bin");

  a_nyquist_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bin_index_o == BIN_W'(HALF) |-> last_bin_o)
    else $error("Nyquist bin without last flag");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !push)
    else $error("queue overrun");
`endif

endmodule

@@ tb/radix2_fft_spectrum_test.sv @@
`timescale 1ns / 1ps

module radix2_fft_spectrum_test;
  import r2fft_pkg::*;

  typedef struct {
    logic [BIN_W-1:0] idx;
    logic [VAL_W-1:0] val;
    logic             last;
  } bin_t;

  typedef enum int {FR_MAX, FR_MIN, FR_ALT, FR_RAND} frame_kind_e;

  localparam int HOLD_CYCLES = 2500;
  localparam int HOLD_AT_BIN = 40;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic                    cfg_data_i = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic signed [SMP_W-1:0] sample_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [BIN_W-1:0]        bin_index_o;
  logic [VAL_W-1:0]        bin_value_o;
  logic                    last_bin_o;

  logic signed [SMP_W-1:0] pending_samples[$];
  bin_t                    expected_bins[$];

  // spectrum model state
  longint    cos_tw[HALF];
  longint    sin_tw[HALF];
  longint    re_mem[FRAME_SIZE];
  longint    im_mem[FRAME_SIZE];
  int        fill_count = 0;
  logic      mode_q = 1'b0;
  int        errors = 0;
  int        bins_seen = 0;
  int        drv_wait = 0;
  int        mon_wait = 0;
  int        hold_left = 0;
  bit        hold_done = 0;

  radix2_fft_spectrum DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .bin_index_o(bin_index_o),
    .bin_value_o(bin_value_o),
    .last_bin_o (last_bin_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Q30 Taylor series for sin and cos of 2*pi*m/FRAME_SIZE
  function automatic void sincos_q30(input longint unsigned m,
                                     output longint unsigned sv,
                                     output longint unsigned cv);
    longint unsigned x, x2, ts, tc;
    longint          s, c;
    x  = (64'd6746518852 * m + FRAME_SIZE / 2) / FRAME_SIZE;
    x2 = (x * x + 64'd536870912) >> 30;
    s  = x;
    c  = 64'd1073741824;
    ts = x;
    tc = 64'd1073741824;
    for (int k = 1; k <= 8; k++) begin
      ts = ((ts * x2 + 64'd536870912) >> 30) / ((2 * k) * (2 * k + 1));
      tc = ((tc * x2 + 64'd536870912) >> 30) / ((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        s -= ts;
        c -= tc;
      end else begin
        s += ts;
        c += tc;
      end
    end
    sv = (s < 0) ? 0 : s;
    cv = (c < 0) ? 0 : c;
  endfunction

  function automatic longint quant_tw(input longint unsigned v);
    longint unsigned r;
    r = (v + (64'd1 << (30 - TW_BITS))) >> (31 - TW_BITS);
    return (r > 32767) ? 32767 : r;
  endfunction

  function automatic void build_twiddles();
    longint unsigned a, b;
    longint          s0, c0;
    int              q, r;
    for (int t = 0; t < HALF; t++) begin
      q = t / (FRAME_SIZE / 4);
      r = t % (FRAME_SIZE / 4);
      if (r <= FRAME_SIZE / 8) begin
        sincos_q30(r, a, b);
        s0 = quant_tw(a);
        c0 = quant_tw(b);
      end else begin
        sincos_q30(FRAME_SIZE / 4 - r, a, b);
        s0 = quant_tw(b);
        c0 = quant_tw(a);
      end
      if (q == 0) begin
        cos_tw[t] = c0;
        sin_tw[t] = s0;
      end else begin
        cos_tw[t] = -s0;
        sin_tw[t] = c0;
      end
    end
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, bitv;
    r    = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // store one sample; on a full frame run the FFT and queue bins 0..N/2
  function automatic void predict_spectrum(input logic signed [SMP_W-1:0] smp);
    logic [FRAME_LOG-1:0] addr;
    int                   span, stride, ti, k1;
    longint               c, s, tr, tim, r, m;
    longint unsigned      ar, am, p, v;
    bin_t                 b;
    for (int i = 0; i < FRAME_LOG; i++) addr[FRAME_LOG-1-i] = fill_count[i];
    re_mem[addr] = smp;
    im_mem[addr] = 0;
    fill_count++;
    if (fill_count < FRAME_SIZE) return;
    fill_count = 0;
    span   = 1;
    stride = HALF;
    for (int st = 0; st < FRAME_LOG; st++) begin
      for (int j = 0; j < span; j++) begin
        ti = (j * stride) & (HALF - 1);
        c  = cos_tw[ti];
        s  = sin_tw[ti];
        for (int k = j; k + span < FRAME_SIZE; k += 2 * span) begin
          k1  = k + span;
          // rounding by adding half then flooring
          tr  = (c * re_mem[k1] - s * im_mem[k1] + (64'sd1 <<< (TW_BITS - 2))) >>> (TW_BITS - 1);
          tim = (c * im_mem[k1] + s * re_mem[k1] + (64'sd1 <<< (TW_BITS - 2))) >>> (TW_BITS - 1);
          re_mem[k1] = re_mem[k] - tr;
          im_mem[k1] = im_mem[k] - tim;
          re_mem[k] += tr;
          im_mem[k] += tim;
        end
      end
      span *= 2;
      stride /= 2;
    end
    for (int bi = 0; bi <= HALF; bi++) begin
      r  = re_mem[bi];
      m  = im_mem[bi];
      ar = (r < 0) ? -r : r;
      am = (m < 0) ? -m : m;
      p  = ar * ar + am * am;
      if (!mode_q) begin
        v = int_sqrt(p);
      end else begin
        v = p;
        if (bi == 0 || bi == HALF) v >>= 2;
      end
      if (v > VALUE_MAX) v = VALUE_MAX;
      b.idx  = bi[BIN_W-1:0];
      b.val  = v[VAL_W-1:0];
      b.last = (bi == HALF);
      expected_bins.push_back(b);
    end
  endfunction

  function automatic void push_frame(input frame_kind_e kind);
    logic signed [SMP_W-1:0] smp;
    for (int i = 0; i < FRAME_SIZE; i++) begin
      case (kind)
        FR_MAX: smp = 16'sh7fff;
        FR_MIN: smp = -16'sh8000;
        FR_ALT: smp = (i % 2) ? -16'sh8000 : 16'sh7fff;
        default: begin
          case ($urandom_range(0, 3))
            0: smp = ($urandom_range(0, 1)) ? 16'sh7fff : -16'sh8000;
            1: smp = $signed(16'($urandom_range(0, 511))) - 16'sd256;
            default: smp = 16'($urandom);
          endcase
        end
      endcase
      pending_samples.push_back(smp);
    end
  endfunction

  // drive samples; a random gap, possibly none, follows each item
  always @(posedge clk_i or negedge rst_ni) begin
    logic nv;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      drv_wait = 0;
    end else begin
      nv = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        predict_spectrum(sample_i);
        nv = 1'b0;
      end
      if (!nv) begin
        if (drv_wait > 0) begin
          drv_wait--;
        end else if (pending_samples.size() > 0) begin
          sample_i <= pending_samples.pop_front();
          nv = 1'b1;
          drv_wait = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
        end
      end
      in_valid_i <= nv;
    end
  end

  // accept bins and compare against the oldest expected bin
  always @(posedge clk_i or negedge rst_ni) begin
    bin_t b;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_bins.size() == 0) begin
          $error("unexpected bin index=%0d value=%0d", bin_index_o, bin_value_o);
          errors++;
        end else begin
          b = expected_bins.pop_front();
          if (bin_index_o !== b.idx) begin
            $error("bin_index expected %0d actual %0d", b.idx, bin_index_o);
            errors++;
          end
          if (bin_value_o !== b.val) begin
            $error("bin_value expected %0d actual %0d", b.val, bin_value_o);
            errors++;
          end
          if (last_bin_o !== b.last) begin
            $error("last_bin expected %0d actual %0d", b.last, last_bin_o);
            errors++;
          end
        end
        bins_seen++;
        mon_wait = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
        // hold off once for a long stretch so the input backs up
        if (!hold_done && bins_seen == HOLD_AT_BIN) begin
          hold_done = 1;
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (mon_wait > 0) begin
        mon_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic drain();
    while (pending_samples.size() > 0 || in_valid_i || expected_bins.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= m;
    mode_q = m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    build_twiddles();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // magnitude mode: full-scale DC, Nyquist tone, then random frames
    write_mode(1'b0);
    push_frame(FR_MAX);
    push_frame(FR_ALT);
    push_frame(FR_RAND);
    push_frame(FR_RAND);
    drain();

    // power mode: full negative DC and a random frame
    write_mode(1'b1);
    push_frame(FR_MIN);
    push_frame(FR_RAND);
    drain();

    // back to magnitude mode
    write_mode(1'b0);
    push_frame(FR_RAND);
    drain();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ files.f @@
src/r2fft_pkg.sv
src/r2fft_front.sv
src/r2fft_fifo.sv
src/r2fft_back.sv
src/radix2_fft_spectrum.sv
tb/radix2_fft_spectrum_test.sv
